// ===== hw/rtl/zsep_pkg.sv =====
package zsep_pkg;

  // Local file header layout
  localparam logic [31:0] LOCAL_SIG  = 32'h04034b50;
  localparam logic [4:0]  HEADER_LEN = 5'd30;
  localparam logic [4:0]  POS_SIG_LAST = 5'd3;
  localparam logic [4:0]  POS_METHOD_LO = 5'd8;
  localparam logic [4:0]  POS_METHOD_HI = 5'd9;
  localparam logic [4:0]  POS_SIZE_LO = 5'd22;
  localparam logic [4:0]  POS_SIZE_HI = 5'd25;
  localparam logic [4:0]  POS_NLEN_LO = 5'd26;
  localparam logic [4:0]  POS_NLEN_HI = 5'd27;
  localparam logic [4:0]  POS_XLEN_LO = 5'd28;
  localparam logic [4:0]  POS_XLEN_HI = 5'd29;

  // Last five name bytes for ".usdc" and ".usda"
  localparam logic [39:0] TAIL_USDC = 40'h2E75736463;
  localparam logic [39:0] TAIL_USDA = 40'h2E75736461;
  localparam logic [15:0] TAIL_MIN_LEN = 16'd5;

  // Root slot value meaning nothing found yet
  localparam logic [8:0] NOT_FOUND = 9'd256;

  localparam int DEFAULT_ENTRY_LIMIT = 256;

  // Depth of the record queue between parser and output
  localparam int Q_DEPTH = 4;

  // Record kinds
  localparam logic REC_ENTRY   = 1'b0;
  localparam logic REC_SUMMARY = 1'b1;

  // Name and root kinds
  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_USDC  = 2'd1;
  localparam logic [1:0] KIND_USDA  = 2'd2;

  // Stop causes
  localparam logic [2:0] STOP_CLEAN     = 3'd0;
  localparam logic [2:0] STOP_BAD_SIG   = 3'd1;
  localparam logic [2:0] STOP_TRUNCATED = 3'd2;
  localparam logic [2:0] STOP_LIMIT     = 3'd3;
  localparam logic [2:0] STOP_OVERSIZE  = 3'd4;

  // Result payload, first field in the highest bits
  typedef struct packed {
    logic [2:0]  stop_cause;
    logic [1:0]  root_kind;
    logic [7:0]  root_index;
    logic [8:0]  found_total;
    logic [1:0]  name_kind;
    logic [31:0] stored_size;
    logic [31:0] data_offset;
    logic [15:0] name_length;
    logic [31:0] header_offset;
    logic [7:0]  entry_index;
  } payload_t;

  typedef struct packed {
    logic     kind;
    logic     last;
    payload_t data;
  } rec_t;

  // Up to two records per byte, compacted: b only valid with a
  typedef struct packed {
    logic a_valid;
    rec_t a;
    logic b_valid;
    rec_t b;
  } push_t;

endpackage

// ===== hw/rtl/zip_stored_entry_stream_parser.sv =====
// Streaming parser for the local headers of a ZIP archive.
// Slave side: one archive byte per transaction on s_axis_tdata; s_axis_tlast
// marks the final byte of the archive.
// Master side: one record per transaction. m_axis_tuser gives the kind:
// 0 for a stored entry (offsets, sizes, name kind), 1 for the summary that
// follows the final byte (entry count, root layer choice, stop cause).
// m_axis_tlast is high on the last record caused by one input byte.
// Throughput: one byte per cycle while the record queue has room. The front
// parser updates its counters and header fields in the cycle the byte is taken;
// a record is registered into the record queue and leaves it on the master side.
// A four-deep record queue separates parser and output; a byte is taken
// whenever the queue has two free slots, so a stalled receiver holds off
// the slave side only once fewer than two slots are left.
// Reset clears the parser to the header phase at offset zero and empties
// the queue; after each summary the parser rearms for a new archive.
module zip_stored_entry_stream_parser
  import zsep_pkg::*;
#(
  parameter int ENTRY_LIMIT = DEFAULT_ENTRY_LIMIT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tlast,   // end_of_archive
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // entry_index, header_offset, name_length, data_offset, stored size,
  // name_kind, stored entry total, root_index, root_kind, stop_cause
  output logic [143:0] m_axis_tdata,
  output logic         m_axis_tuser,   // record_kind
  output logic         m_axis_tlast    // last_of_run
);

  logic  room;
  logic  fire;
  push_t push;

  // Accept a byte whenever the queue can hold its records
  assign s_axis_tready = room;
  assign fire          = s_axis_tvalid && room;

  zsep_front #(
    .ENTRY_LIMIT(ENTRY_LIMIT)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (s_axis_tdata),
    .eoa_i  (s_axis_tlast),
    .push_o (push)
  );

  // Hold records until the receiver takes them
  zsep_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/zsep_front.sv =====
module zsep_front
  import zsep_pkg::*;
#(
  parameter int ENTRY_LIMIT = DEFAULT_ENTRY_LIMIT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       eoa_i,
  output push_t      push_o
);

  typedef enum logic [2:0] {PH_HEADER, PH_NAME, PH_EXTRA, PH_DATA, PH_STOP} phase_e;

  localparam logic [8:0] LIMIT = 9'(ENTRY_LIMIT);

  phase_e      phase_q, phase_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] off_q, off_d;
  logic [31:0] start_q, start_d;
  logic [23:0] sig_q, sig_d;
  logic        mnz_q, mnz_d;
  logic [31:0] size_q, size_d;
  logic [15:0] nlen_q, nlen_d;
  logic [15:0] xlen_q, xlen_d;
  logic [31:0] skip_q, skip_d;
  logic [39:0] tail_q, tail_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [8:0]  usdc_q, usdc_d;
  logic [8:0]  usda_q, usda_d;
  logic [2:0]  stop_q, stop_d;

  logic        name_done, extra_done, finish;
  logic        emit_entry;
  logic [1:0]  kind;
  logic [4:0]  rel;
  payload_t    ent, sum;
  rec_t        ent_rec, sum_rec;

  always_comb begin
    phase_d = phase_q;  pos_d  = pos_q;   off_d  = off_q;   start_d = start_q;
    sig_d   = sig_q;    mnz_d  = mnz_q;   size_d = size_q;  nlen_d  = nlen_q;
    xlen_d  = xlen_q;   skip_d = skip_q;  tail_d = tail_q;  cnt_d   = cnt_q;
    usdc_d  = usdc_q;   usda_d = usda_q;  stop_d = stop_q;
    name_done = 1'b0;  extra_done = 1'b0;  finish = 1'b0;
    emit_entry = 1'b0;
    kind = KIND_OTHER;
    rel  = 5'd0;
    ent  = '0;
    sum  = '0;

    if (phase_q != PH_STOP) begin
      if (&off_q) begin
        phase_d = PH_STOP;
        stop_d  = STOP_OVERSIZE;
      end else if (phase_q == PH_HEADER && pos_q == 5'd0 && cnt_q >= LIMIT) begin
        phase_d = PH_STOP;
        stop_d  = STOP_LIMIT;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (pos_q == 5'd0) begin
              start_d = off_q;
              sig_d   = '0;
              mnz_d   = 1'b0;
              size_d  = '0;
              nlen_d  = '0;
              xlen_d  = '0;
              tail_d  = '0;
            end
            if (pos_q < POS_SIG_LAST) begin
              sig_d[8*pos_q[1:0] +: 8] = byte_i;
            end else if (pos_q == POS_METHOD_LO) begin
              mnz_d = (byte_i != 8'd0);
            end else if (pos_q == POS_METHOD_HI) begin
              mnz_d = mnz_q | (byte_i != 8'd0);
            end else if (pos_q inside {[POS_SIZE_LO:POS_SIZE_HI]}) begin
              rel = pos_q - POS_SIZE_LO;
              size_d[8*rel[1:0] +: 8] = byte_i;
            end else if (pos_q == POS_NLEN_LO) begin
              nlen_d[7:0] = byte_i;
            end else if (pos_q == POS_NLEN_HI) begin
              nlen_d[15:8] = byte_i;
            end else if (pos_q == POS_XLEN_LO) begin
              xlen_d[7:0] = byte_i;
            end else if (pos_q == POS_XLEN_HI) begin
              xlen_d[15:8] = byte_i;
            end

            if (pos_q == POS_SIG_LAST && {byte_i, sig_q} != LOCAL_SIG) begin
              phase_d = PH_STOP;
              stop_d  = STOP_BAD_SIG;
            end else if (pos_q != HEADER_LEN - 5'd1) begin
              pos_d = pos_q + 5'd1;
            end else begin
              pos_d = 5'd0;
              if (nlen_d != 16'd0) begin
                phase_d = PH_NAME;
                skip_d  = {16'd0, nlen_d};
              end else begin
                name_done = 1'b1;
              end
            end
          end
          PH_NAME: begin
            tail_d = {tail_q[31:0], byte_i};
            skip_d = skip_q - 32'd1;
            name_done = (skip_q == 32'd1);
          end
          PH_EXTRA: begin
            skip_d = skip_q - 32'd1;
            extra_done = (skip_q == 32'd1);
          end
          PH_DATA: begin
            skip_d = skip_q - 32'd1;
            finish = (skip_q == 32'd1);
          end
          default: ;
        endcase
      end
    end

    // Walk past empty name, extra and data sections in the same byte
    if (name_done) begin
      if (xlen_d != 16'd0) begin
        phase_d = PH_EXTRA;
        skip_d  = {16'd0, xlen_d};
      end else begin
        extra_done = 1'b1;
      end
    end
    if (extra_done) begin
      if (size_d != 32'd0) begin
        phase_d = PH_DATA;
        skip_d  = size_d;
      end else begin
        finish = 1'b1;
      end
    end
    if (finish) begin
      phase_d = PH_HEADER;
      pos_d   = 5'd0;
      if (!mnz_d) begin
        if (nlen_d >= TAIL_MIN_LEN && tail_d == TAIL_USDC) begin
          kind = KIND_USDC;
        end else if (nlen_d >= TAIL_MIN_LEN && tail_d == TAIL_USDA) begin
          kind = KIND_USDA;
        end
        if (kind == KIND_USDC && usdc_q == NOT_FOUND) usdc_d = cnt_q;
        if (kind == KIND_USDA && usda_q == NOT_FOUND) usda_d = cnt_q;
        emit_entry        = 1'b1;
        ent.entry_index   = cnt_q[7:0];
        ent.header_offset = start_d;
        ent.name_length   = nlen_d;
        ent.data_offset   = off_q + 32'd1 - size_d;
        ent.stored_size   = size_d;
        ent.name_kind     = kind;
        cnt_d             = cnt_q + 9'd1;
      end
    end

    if (!(&off_q)) off_d = off_q + 32'd1;

    // Summary is built from the state after this byte
    sum.found_total = cnt_d;
    if (phase_d != PH_STOP) begin
      sum.stop_cause = (phase_d == PH_HEADER && pos_d == 5'd0) ? STOP_CLEAN : STOP_TRUNCATED;
    end else begin
      sum.stop_cause = stop_d;
    end
    if (usdc_d != NOT_FOUND) begin
      sum.root_index = usdc_d[7:0];
      sum.root_kind  = KIND_USDC;
    end else if (usda_d != NOT_FOUND) begin
      sum.root_index = usda_d[7:0];
      sum.root_kind  = KIND_USDA;
    end

    // End of archive rearms the parser for the next one
    if (eoa_i) begin
      phase_d = PH_HEADER; pos_d  = '0; off_d  = '0; start_d = '0;
      sig_d   = '0;        mnz_d  = '0; size_d = '0; nlen_d  = '0;
      xlen_d  = '0;        skip_d = '0; tail_d = '0; cnt_d   = '0;
      usdc_d  = NOT_FOUND; usda_d = NOT_FOUND;       stop_d  = STOP_CLEAN;
    end
  end

  always_comb begin
    ent_rec.kind = REC_ENTRY;
    ent_rec.last = !eoa_i;
    ent_rec.data = ent;
    sum_rec.kind = REC_SUMMARY;
    sum_rec.last = 1'b1;
    sum_rec.data = sum;
    push_o.a_valid = fire_i && (emit_entry || eoa_i);
    push_o.a       = emit_entry ? ent_rec : sum_rec;
    push_o.b_valid = fire_i && emit_entry && eoa_i;
    push_o.b       = sum_rec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER; pos_q  <= '0; off_q  <= '0; start_q <= '0;
      sig_q   <= '0;        mnz_q  <= '0; size_q <= '0; nlen_q  <= '0;
      xlen_q  <= '0;        skip_q <= '0; tail_q <= '0; cnt_q   <= '0;
      usdc_q  <= NOT_FOUND; usda_q <= NOT_FOUND;        stop_q  <= STOP_CLEAN;
    end else if (fire_i) begin
      phase_q <= phase_d; pos_q  <= pos_d;  off_q  <= off_d;  start_q <= start_d;
      sig_q   <= sig_d;   mnz_q  <= mnz_d;  size_q <= size_d; nlen_q  <= nlen_d;
      xlen_q  <= xlen_d;  skip_q <= skip_d; tail_q <= tail_d; cnt_q   <= cnt_d;
      usdc_q  <= usdc_d;  usda_q <= usda_d; stop_q <= stop_d;
    end
  end

endmodule

// ===== hw/rtl/zsep_back.sv =====
module zsep_back
  import zsep_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  push_t          push_i,
  output logic           room_o,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [143:0]   m_axis_tdata,
  output logic           m_axis_tuser,
  output logic           m_axis_tlast
);

  localparam int AW = $clog2(Q_DEPTH);

  rec_t          mem_q [Q_DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          pop;
  logic [AW:0]   n_push;
  logic [AW-1:0] wr_b;
  rec_t          head;

  assign pop    = m_axis_tvalid && m_axis_tready;
  assign n_push = (AW+1)'(push_i.a_valid) + (AW+1)'(push_i.b_valid);
  assign wr_b   = wr_q + AW'(1);
  // Take a byte only when both record slots it may need are free
  assign room_o = (cnt_q <= (AW+1)'(Q_DEPTH - 2));

  assign head          = mem_q[rd_q];
  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = head.data;
  assign m_axis_tuser  = head.kind;
  assign m_axis_tlast  = head.last;

  always_ff @(posedge clk_i) begin
    if (push_i.a_valid) mem_q[wr_q] <= push_i.a;
    if (push_i.b_valid) mem_q[wr_b] <= push_i.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push[AW-1:0];
      if (pop) rd_q <= rd_q + AW'(1);
      cnt_q <= cnt_q + n_push - (AW+1)'(pop);
    end
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import zsep_pkg::*;

  localparam int ENTRY_CAP = DEFAULT_ENTRY_LIMIT;
  // A hold-off of HOLD_CYCLES is the longest legal pause in this run; the
  // watchdog fails the run once its quiet count reaches QUIET_LIMIT, i.e. with nothing accepted on either side.
  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_BYTES_PER_PHASE = 200;

  localparam logic [15:0] METHOD_STORED  = 16'd0;
  localparam logic [15:0] METHOD_DEFLATE = 16'd8;

  typedef enum logic [2:0] {
    SCAN_HEADER,
    SCAN_NAME,
    SCAN_EXTRA,
    SCAN_DATA,
    SCAN_HALTED
  } scan_phase_e;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // data_byte
  logic         s_axis_tlast = 1'b0; // end_of_archive
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // entry_index, header_offset, name_length, data_offset, stored size,
  // name_kind, stored entry total, root_index, root_kind, stop_cause
  logic [143:0] m_axis_tdata;
  logic         m_axis_tuser;        // record_kind
  logic         m_axis_tlast;        // last_of_run

  zip_stored_entry_stream_parser #(
    .ENTRY_LIMIT(ENTRY_CAP)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_served = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int mismatch_count = 0;

  rec_t       expected_records[$];
  logic [7:0] archive_bytes[$];

  // Shadow of the header scanner
  scan_phase_e scan_phase;
  int          hdr_pos;
  logic [31:0] arc_offset;
  logic [31:0] hdr_start;
  logic [31:0] hdr_sig;
  logic [15:0] hdr_method;
  logic [31:0] hdr_data_len;
  logic [15:0] hdr_nlen;
  logic [15:0] hdr_xlen;
  logic [31:0] remaining;
  logic [39:0] name_tail;
  logic [8:0]  stored_count;
  logic [8:0]  first_usdc;
  logic [8:0]  first_usda;
  logic [2:0]  halt_cause;

  task automatic rearm_scanner();
    scan_phase    = SCAN_HEADER;
    hdr_pos       = 0;
    arc_offset    = '0;
    hdr_start     = '0;
    hdr_sig       = '0;
    hdr_method    = '0;
    hdr_data_len  = '0;
    hdr_nlen      = '0;
    hdr_xlen      = '0;
    remaining     = '0;
    name_tail     = '0;
    stored_count  = '0;
    first_usdc    = NOT_FOUND;
    first_usda    = NOT_FOUND;
    halt_cause    = STOP_CLEAN;
  endtask

  // Entry done: stored entries emit a record, all others vanish.
  task automatic close_entry(input logic [31:0] cur);
    rec_t       r;
    logic [1:0] nkind;
    scan_phase = SCAN_HEADER;
    hdr_pos    = 0;
    if (hdr_method == METHOD_STORED) begin
      nkind = KIND_OTHER;
      if (hdr_nlen >= TAIL_MIN_LEN && name_tail == TAIL_USDC) nkind = KIND_USDC;
      else if (hdr_nlen >= TAIL_MIN_LEN && name_tail == TAIL_USDA) nkind = KIND_USDA;
      if (nkind == KIND_USDC && first_usdc == NOT_FOUND) first_usdc = stored_count;
      if (nkind == KIND_USDA && first_usda == NOT_FOUND) first_usda = stored_count;
      r = '0;
      r.kind               = REC_ENTRY;
      r.data.entry_index   = stored_count[7:0];
      r.data.header_offset = hdr_start;
      r.data.name_length   = hdr_nlen;
      r.data.data_offset   = cur + 32'd1 - hdr_data_len;
      r.data.stored_size   = hdr_data_len;
      r.data.name_kind     = nkind;
      expected_records.push_back(r);
      stored_count = stored_count + 9'd1;
    end
  endtask

  task automatic leave_extra(input logic [31:0] cur);
    if (hdr_data_len != '0) begin
      scan_phase = SCAN_DATA;
      remaining  = hdr_data_len;
    end else begin
      close_entry(cur);
    end
  endtask

  task automatic leave_name(input logic [31:0] cur);
    if (hdr_xlen != '0) begin
      scan_phase = SCAN_EXTRA;
      remaining  = {16'd0, hdr_xlen};
    end else begin
      leave_extra(cur);
    end
  endtask

  // Advance the shadow scanner by one accepted byte and queue its records.
  task automatic predict_byte(input logic [7:0] b, input logic eoa);
    int          first_new;
    logic [31:0] cur;
    rec_t        r;
    first_new = expected_records.size();
    cur = arc_offset;
    if (scan_phase != SCAN_HALTED) begin
      if (cur == '1) begin
        scan_phase = SCAN_HALTED;
        halt_cause = STOP_OVERSIZE;
      end else if (scan_phase == SCAN_HEADER && hdr_pos == 0 && stored_count >= ENTRY_CAP) begin
        scan_phase = SCAN_HALTED;
        halt_cause = STOP_LIMIT;
      end else begin
        case (scan_phase)
          SCAN_HEADER: begin
            if (hdr_pos == 0) begin
              hdr_start     = cur;
              name_tail     = '0;
              hdr_sig       = '0;
              hdr_method    = '0;
              hdr_data_len  = '0;
              hdr_nlen      = '0;
              hdr_xlen      = '0;
            end
            if (hdr_pos <= POS_SIG_LAST) begin
              hdr_sig[8*hdr_pos +: 8] = b;
            end else if (hdr_pos == POS_METHOD_LO || hdr_pos == POS_METHOD_HI) begin
              hdr_method[8*(hdr_pos - POS_METHOD_LO) +: 8] = b;
            end else if (hdr_pos >= POS_SIZE_LO && hdr_pos <= POS_SIZE_HI) begin
              hdr_data_len[8*(hdr_pos - POS_SIZE_LO) +: 8] = b;
            end else if (hdr_pos == POS_NLEN_LO || hdr_pos == POS_NLEN_HI) begin
              hdr_nlen[8*(hdr_pos - POS_NLEN_LO) +: 8] = b;
            end else if (hdr_pos == POS_XLEN_LO || hdr_pos == POS_XLEN_HI) begin
              hdr_xlen[8*(hdr_pos - POS_XLEN_LO) +: 8] = b;
            end
            if (hdr_pos == POS_SIG_LAST && hdr_sig != LOCAL_SIG) begin
              scan_phase = SCAN_HALTED;
              halt_cause = STOP_BAD_SIG;
            end else if (hdr_pos + 1 < HEADER_LEN) begin
              hdr_pos++;
            end else begin
              hdr_pos = 0;
              if (hdr_nlen != '0) begin
                scan_phase = SCAN_NAME;
                remaining  = {16'd0, hdr_nlen};
              end else begin
                leave_name(cur);
              end
            end
          end
          SCAN_NAME: begin
            name_tail = {name_tail[31:0], b};
            remaining = remaining - 32'd1;
            if (remaining == '0) leave_name(cur);
          end
          SCAN_EXTRA: begin
            remaining = remaining - 32'd1;
            if (remaining == '0) leave_extra(cur);
          end
          SCAN_DATA: begin
            remaining = remaining - 32'd1;
            if (remaining == '0) close_entry(cur);
          end
          default: ;
        endcase
      end
    end
    if (arc_offset != '1) arc_offset = arc_offset + 32'd1;

    if (eoa) begin
      if (scan_phase != SCAN_HALTED) begin
        halt_cause = (scan_phase == SCAN_HEADER && hdr_pos == 0) ? STOP_CLEAN : STOP_TRUNCATED;
      end
      r = '0;
      r.kind              = REC_SUMMARY;
      r.data.found_total  = stored_count;
      if (first_usdc != NOT_FOUND) begin
        r.data.root_index = first_usdc[7:0];
        r.data.root_kind  = KIND_USDC;
      end else if (first_usda != NOT_FOUND) begin
        r.data.root_index = first_usda[7:0];
        r.data.root_kind  = KIND_USDA;
      end
      r.data.stop_cause = halt_cause;
      expected_records.push_back(r);
      rearm_scanner();
    end

    // Flag the final record caused by this byte
    if (expected_records.size() > first_new) begin
      r = expected_records[expected_records.size() - 1];
      r.last = 1'b1;
      expected_records[expected_records.size() - 1] = r;
    end
  endtask

  // Offer one byte, hold it until taken, then predict.
  task automatic send_byte(input logic [7:0] b, input logic eoa);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoa;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_byte(b, eoa);
    bytes_sent++;
  endtask

  // Drop valid and pause until every queued record has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_records.size() != 0) @(posedge clk_i);
  endtask

  task automatic add_header(input logic [31:0] sig, input logic [15:0] method,
                            input logic [31:0] data_len, input logic [15:0] nlen_v,
                            input logic [15:0] xlen_v);
    logic [7:0] v;
    for (int i = 0; i < HEADER_LEN; i++) begin
      v = 8'($urandom_range(255));
      if (i <= POS_SIG_LAST) v = sig[8*i +: 8];
      else if (i == POS_METHOD_LO || i == POS_METHOD_HI) v = method[8*(i - POS_METHOD_LO) +: 8];
      else if (i >= POS_SIZE_LO && i <= POS_SIZE_HI) v = data_len[8*(i - POS_SIZE_LO) +: 8];
      else if (i == POS_NLEN_LO || i == POS_NLEN_HI) v = nlen_v[8*(i - POS_NLEN_LO) +: 8];
      else if (i >= POS_XLEN_LO) v = xlen_v[8*(i - POS_XLEN_LO) +: 8];
      archive_bytes.push_back(v);
    end
  endtask

  task automatic add_noise(input int count);
    for (int i = 0; i < count; i++) archive_bytes.push_back(8'($urandom_range(255)));
  endtask

  // Full entry; the name ends in the chosen suffix, cut short when the name is.
  task automatic add_entry(input logic [15:0] method, input int data_len, input int nm_bytes,
                           input int xt_bytes, input logic [1:0] suffix);
    int         k;
    logic [7:0] v;
    add_header(LOCAL_SIG, method, 32'(data_len), 16'(nm_bytes), 16'(xt_bytes));
    for (int i = 0; i < nm_bytes; i++) begin
      k = nm_bytes - 1 - i;
      v = 8'($urandom_range(255));
      if (k < 5 && suffix == KIND_USDC) v = TAIL_USDC[8*k +: 8];
      else if (k < 5 && suffix == KIND_USDA) v = TAIL_USDA[8*k +: 8];
      archive_bytes.push_back(v);
    end
    add_noise(xt_bytes + data_len);
  endtask

  // Send the built archive with tlast on its final byte.
  task automatic stream_archive();
    foreach (archive_bytes[i]) send_byte(archive_bytes[i], i == archive_bytes.size() - 1);
    archive_bytes.delete();
  endtask

  // Mostly well-formed archives; some cut short, some corrupt, some noise.
  task automatic add_random_archive();
    int n_entries;
    int style;
    int cut;
    n_entries = $urandom_range(4);
    style = $urandom_range(99);
    if (style < 90 && n_entries == 0) n_entries = 1;
    for (int i = 0; i < n_entries; i++) begin
      add_entry(($urandom_range(99) < 80) ? METHOD_STORED : 16'($urandom_range(1, 65535)),
                ($urandom_range(99) < 15) ? 0 : $urandom_range(1, 12),
                $urandom_range(10),
                ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 4),
                2'($urandom_range(2)));
    end
    if (style >= 70 && style < 82) begin
      cut = $urandom_range(1, 40);
      while (cut > 0 && archive_bytes.size() > 1) begin
        void'(archive_bytes.pop_back());
        cut--;
      end
    end else if (style >= 82 && style < 92) begin
      add_header(LOCAL_SIG ^ (32'd1 << $urandom_range(31)), 16'($urandom_range(65535)),
                 32'($urandom_range(8)), 16'($urandom_range(8)), 16'($urandom_range(8)));
      add_noise($urandom_range(20));
    end else if (style >= 92) begin
      add_noise($urandom_range(1, 40));
    end
  endtask

  task automatic test_entry_layouts();
    // Lone empty stored entry: entry and summary leave on the same byte
    add_entry(METHOD_STORED, 0, 0, 0, KIND_OTHER);
    stream_archive();
    add_entry(METHOD_STORED, 3, 6, 2, KIND_USDA);
    add_entry(METHOD_DEFLATE, 5, 7, 1, KIND_USDC);
    add_entry(METHOD_STORED, 1, 5, 0, KIND_USDC);
    add_entry(16'hFFFF, 0, 0, 0, KIND_OTHER);
    add_entry(METHOD_STORED, 2, 4, 0, KIND_USDC);
    add_entry(METHOD_STORED, 0, 5, 3, KIND_USDA);
    add_entry(METHOD_STORED, 4, 9, 0, KIND_USDC);
    stream_archive();
    // Nothing stored: no root, count zero
    add_entry(16'd1, 2, 5, 0, KIND_USDC);
    add_entry(16'h8000, 0, 3, 2, KIND_OTHER);
    stream_archive();
    wait_drained();
  endtask

  task automatic test_stop_causes();
    add_noise(1);
    stream_archive();
    add_header(LOCAL_SIG ^ 32'h8000_0000, METHOD_STORED, 0, 0, 0);
    add_noise(10);
    stream_archive();
    add_entry(METHOD_STORED, 2, 5, 0, KIND_USDA);
    add_header(LOCAL_SIG ^ 32'h0000_0001, METHOD_STORED, 0, 0, 0);
    stream_archive();
    add_entry(METHOD_STORED, 1, 0, 0, KIND_OTHER);
    add_header(32'h0, METHOD_STORED, 0, 0, 0);
    stream_archive();
    // Cut inside the header
    add_entry(METHOD_STORED, 0, 5, 0, KIND_USDC);
    add_header(LOCAL_SIG, METHOD_STORED, 4, 3, 2);
    repeat (10) void'(archive_bytes.pop_back());
    stream_archive();
    // Cut inside name, extra and data with the widest header fields
    add_header(LOCAL_SIG, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
    add_noise(8);
    stream_archive();
    add_header(LOCAL_SIG, METHOD_STORED, 32'hFFFF_FFFF, 16'h0, 16'hFFFF);
    add_noise(3);
    stream_archive();
    add_header(LOCAL_SIG, METHOD_STORED, 32'hFFFF_FFFF, 16'h0, 16'h0);
    add_noise(5);
    stream_archive();
    // Header complete, data never arrives
    add_header(LOCAL_SIG, METHOD_STORED, 32'd2, 16'h0, 16'h0);
    stream_archive();
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_pct  = 0;
    stall_pct = 0;
    @(negedge clk_i);
    hold_requests++;
    @(posedge clk_i);
    // Back-to-back empty entries fill the record queue during the hold
    for (int i = 0; i < 12; i++) add_entry(METHOD_STORED, 0, 0, 0, KIND_OTHER);
    stream_archive();
    wait_drained();
  endtask

  task automatic test_random_archives();
    int idle_by_phase[4]  = '{0, 79, 0, 30};
    int stall_by_phase[4] = '{0, 0, 79, 30};
    int target;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      target = bytes_sent + RANDOM_BYTES_PER_PHASE;
      while (bytes_sent < target) begin
        add_random_archive();
        stream_archive();
      end
    end
  endtask

  task automatic compare_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] seen_v);
    if (want_v !== seen_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", fname, want_v, seen_v);
      mismatch_count++;
    end
  endtask

  task automatic check_record();
    rec_t     want;
    payload_t seen;
    seen = payload_t'(m_axis_tdata);
    if (expected_records.size() == 0) begin
      $error("record with none expected: record_kind %0d", m_axis_tuser);
      mismatch_count++;
    end else begin
      want = expected_records.pop_front();
      compare_field("record_kind", 32'(want.kind), 32'(m_axis_tuser));
      compare_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
      compare_field("entry_index", 32'(want.data.entry_index), 32'(seen.entry_index));
      compare_field("header_offset", want.data.header_offset, seen.header_offset);
      compare_field("name_length", 32'(want.data.name_length), 32'(seen.name_length));
      compare_field("data_offset", want.data.data_offset, seen.data_offset);
      compare_field("stored_size", want.data.stored_size, seen.stored_size);
      compare_field("name_kind", 32'(want.data.name_kind), 32'(seen.name_kind));
      compare_field("found_total", 32'(want.data.found_total), 32'(seen.found_total));
      compare_field("root_index", 32'(want.data.root_index), 32'(seen.root_index));
      compare_field("root_kind", 32'(want.data.root_kind), 32'(seen.root_kind));
      compare_field("stop_cause", 32'(want.data.stop_cause), 32'(seen.stop_cause));
    end
  endtask

  // Record sink: check each transaction, then pick tready for the next edge.
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) check_record();
    if (hold_requests != holds_served) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rearm_scanner();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_entry_layouts();
    test_stop_causes();
    test_backpressure();
    test_random_archives();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_records.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/zsep_pkg.sv
hw/rtl/zsep_front.sv
hw/rtl/zsep_back.sv
hw/rtl/zip_stored_entry_stream_parser.sv
dv/testbench.sv
